// ===== hdl/periodic_and_oneshot_tick_scheduler_macros.svh =====
// Assertion macros for the tick scheduler.
// Depends on nothing; the asserting file supplies i_clk and i_rst_n.
`ifndef PERIODIC_AND_ONESHOT_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_AND_ONESHOT_TICK_SCHEDULER_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define POTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tick scheduler check failed");
// Consequent must hold in the cycle after the antecedent.
`define POTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tick scheduler check failed");
`else
`define POTS_ASSERT_SAME(label, ante, cons)
`define POTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/pots_pkg.sv =====
// Shared constants, codes and controller/datapath structs of the tick scheduler.
// Depends on nothing.
package pots_pkg;

    localparam int ONESHOT_SLOTS_DEF  = 32;
    localparam int PERIODIC_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF      = 48;

    localparam int KIND_W = 2;
    localparam int SLOT_W = 5;
    localparam int TICK_W = 32;

    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd2;

    localparam logic SRC_ONESHOT  = 1'b0;
    localparam logic SRC_PERIODIC = 1'b1;

    typedef struct packed {
        logic              accept;
        logic              os_check;
        logic              pr_load;
        logic              pr_check;
        logic              flush;
        logic [SLOT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic pr_en;
        logic mod_done;
    } t_stat;

endpackage

// ===== hdl/periodic_and_oneshot_tick_scheduler.sv =====
// Top level of the periodic and one-shot tick scheduler.
// Depends on pots_pkg, pots_ctrl, pots_dp and the assertion macro header.
//
// Usage. An input beat is taken at a rising edge with start high and busy low.
// kind selects a tick, a periodic slot write or a one-shot arm/disarm. Set-up
// beats leave busy low, so another beat may follow at once. A tick beat raises
// busy from the next cycle while the slot table is scanned: first the one-shot
// slots in ascending order, then the periodic slots. Each one-shot slot is a
// RAM read and then a compare. Each periodic slot is a RAM read and a load;
// when the slot is enabled, tick mod period then comes from a one-bit-per-cycle
// restoring divider, and the compare waits for its remainder.
// Each fire leaves as one result beat, shown for one cycle with o_strobe high;
// o_last marks the final beat of the tick, which appears in the cycle busy falls.
// A fire is held back until the next fire or the end of the scan, so that its
// last flag is known; results thus trail their detection. The receiver cannot
// stall and must take each beat. A tick with no fire gives no beat at all. Reset
// (synchronous, active low) disables every periodic slot and disarms every
// one-shot slot at once, through per-slot flags; reset does not clear the RAM
// contents themselves.
`include "periodic_and_oneshot_tick_scheduler_macros.svh"

module periodic_and_oneshot_tick_scheduler #(
    parameter int ONESHOT_SLOTS  = pots_pkg::ONESHOT_SLOTS_DEF,
    parameter int PERIODIC_SLOTS = pots_pkg::PERIODIC_SLOTS_DEF,
    parameter int TIME_BITS      = pots_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pots_pkg::KIND_W-1:0] i_kind,
    input  logic [pots_pkg::TICK_W-1:0] i_tick_count,
    input  logic [TIME_BITS-1:0]        i_now_ms,
    input  logic [pots_pkg::SLOT_W-1:0] i_slot,
    input  logic [pots_pkg::TICK_W-1:0] i_period,
    input  logic [pots_pkg::TICK_W-1:0] i_phase,
    input  logic [TIME_BITS-1:0]        i_deadline_ms,
    input  logic                        i_arm,
    output logic                        o_strobe,
    output logic                        o_source,
    output logic [pots_pkg::SLOT_W-1:0] o_fire_slot,
    output logic [pots_pkg::TICK_W-1:0] o_fire_tick,
    output logic                        o_last
);

    pots_pkg::t_cmd  cmd;
    pots_pkg::t_stat stat;

    // The controller owns the scan index and the sequence; the datapath owns all
    // slot state, the divider and the result registers.
    pots_ctrl #(
        .ONESHOT_SLOTS  (ONESHOT_SLOTS),
        .PERIODIC_SLOTS (PERIODIC_SLOTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pots_dp #(
        .ONESHOT_SLOTS  (ONESHOT_SLOTS),
        .PERIODIC_SLOTS (PERIODIC_SLOTS),
        .TIME_BITS      (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_tick_count  (i_tick_count),
        .i_now_ms      (i_now_ms),
        .i_slot        (i_slot),
        .i_period      (i_period),
        .i_phase       (i_phase),
        .i_deadline_ms (i_deadline_ms),
        .i_arm         (i_arm),
        .o_strobe      (o_strobe),
        .o_source      (o_source),
        .o_fire_slot   (o_fire_slot),
        .o_fire_tick   (o_fire_tick),
        .o_last        (o_last)
    );

    // A beat that is not the last one can only appear while the scan still runs.
    `POTS_ASSERT_SAME(a_more_follow, o_strobe && !o_last, busy)
    // An accepted tick always starts a scan.
    `POTS_ASSERT_NEXT(a_tick_scans, start && !busy && (i_kind == pots_pkg::KIND_TICK), busy)
    // A periodic comparison is only made on a finished remainder.
    `POTS_ASSERT_SAME(a_rem_ready, cmd.pr_check, stat.mod_done)

endmodule

// ===== hdl/pots_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pots_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pots_mod.sv =====
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on pots_pkg for the operand width.
module pots_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pots_pkg::TICK_W-1:0] i_dividend,
    input  logic [pots_pkg::TICK_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pots_pkg::TICK_W-1:0] o_rem
);

    localparam int W  = pots_pkg::TICK_W;
    localparam int CW = $clog2(W + 1);

    logic          r_active;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_div;
    logic [W-1:0]  r_rem;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {r_rem, r_dvd[W-1]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= CW'(W);
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // Operand registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_active) begin
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
            end else begin
                r_rem <= shifted[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/pots_dp.sv =====
// Datapath of the tick scheduler: slot stores, fire tests, pending fire and result beat.
// Depends on pots_pkg, pots_ram and pots_mod.
module pots_dp #(
    parameter int ONESHOT_SLOTS  = pots_pkg::ONESHOT_SLOTS_DEF,
    parameter int PERIODIC_SLOTS = pots_pkg::PERIODIC_SLOTS_DEF,
    parameter int TIME_BITS      = pots_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pots_pkg::t_cmd              i_cmd,
    output pots_pkg::t_stat             o_stat,
    input  logic [pots_pkg::KIND_W-1:0] i_kind,
    input  logic [pots_pkg::TICK_W-1:0] i_tick_count,
    input  logic [TIME_BITS-1:0]        i_now_ms,
    input  logic [pots_pkg::SLOT_W-1:0] i_slot,
    input  logic [pots_pkg::TICK_W-1:0] i_period,
    input  logic [pots_pkg::TICK_W-1:0] i_phase,
    input  logic [TIME_BITS-1:0]        i_deadline_ms,
    input  logic                        i_arm,
    output logic                        o_strobe,
    output logic                        o_source,
    output logic [pots_pkg::SLOT_W-1:0] o_fire_slot,
    output logic [pots_pkg::TICK_W-1:0] o_fire_tick,
    output logic                        o_last
);

    localparam int SW    = pots_pkg::SLOT_W;
    localparam int TW    = pots_pkg::TICK_W;
    localparam int OS_AW = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
    localparam int PR_AW = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;

    logic                 r_armed [ONESHOT_SLOTS];
    logic                 r_en    [PERIODIC_SLOTS];
    logic [TIME_BITS-1:0] r_now;
    logic [TW-1:0]        r_tick;
    logic [TW-1:0]        r_phase;
    logic                 r_pend_valid;
    logic                 r_pend_src;
    logic [SW-1:0]        r_pend_slot;
    logic                 r_out_valid;
    logic                 r_out_src;
    logic [SW-1:0]        r_out_slot;
    logic [TW-1:0]        r_out_tick;
    logic                 r_out_last;

    logic [OS_AW-1:0]     os_idx;
    logic [PR_AW-1:0]     pr_idx;
    logic                 os_slot_ok;
    logic                 pr_slot_ok;
    logic                 os_we;
    logic                 pr_we;
    logic [TIME_BITS-1:0] os_rdata;
    logic [2*TW-1:0]      pr_rdata;
    logic                 mod_start;
    logic                 mod_done;
    logic [TW-1:0]        mod_rem;
    logic                 fire;

    assign os_idx     = i_cmd.idx[OS_AW-1:0];
    assign pr_idx     = i_cmd.idx[PR_AW-1:0];
    assign os_slot_ok = {1'b0, i_slot} < (SW + 1)'(ONESHOT_SLOTS);
    assign pr_slot_ok = {1'b0, i_slot} < (SW + 1)'(PERIODIC_SLOTS);
    assign os_we      = i_cmd.accept && (i_kind == pots_pkg::KIND_ONESHOT) && os_slot_ok;
    assign pr_we      = i_cmd.accept && (i_kind == pots_pkg::KIND_PERIODIC) && pr_slot_ok;

    // Deadlines only matter while armed, so the store needs no clearing.
    pots_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (ONESHOT_SLOTS)
    ) u_os_ram (
        .i_clk   (i_clk),
        .i_we    (os_we),
        .i_waddr (i_slot[OS_AW-1:0]),
        .i_wdata (i_arm ? i_deadline_ms : '0),
        .i_raddr (os_idx),
        .o_rdata (os_rdata)
    );

    pots_ram #(
        .WIDTH (2 * TW),
        .DEPTH (PERIODIC_SLOTS)
    ) u_pr_ram (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (i_slot[PR_AW-1:0]),
        .i_wdata ({i_period, i_phase}),
        .i_raddr (pr_idx),
        .o_rdata (pr_rdata)
    );

    assign mod_start = i_cmd.pr_load && r_en[pr_idx];

    pots_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_tick),
        .i_divisor  (pr_rdata[2*TW-1:TW]),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_stat.pr_en    = r_en[pr_idx];
    assign o_stat.mod_done = mod_done;

    assign fire = (i_cmd.os_check && r_armed[os_idx] && (r_now > os_rdata))
               || (i_cmd.pr_check && (mod_rem == r_phase));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ONESHOT_SLOTS; i++) begin
                r_armed[i] <= 1'b0;
            end
            for (int i = 0; i < PERIODIC_SLOTS; i++) begin
                r_en[i] <= 1'b0;
            end
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (os_we) begin
                r_armed[i_slot[OS_AW-1:0]] <= i_arm;
            end
            if (pr_we) begin
                r_en[i_slot[PR_AW-1:0]] <= (i_period != '0);
            end
            if (i_cmd.os_check && fire) begin
                r_armed[os_idx] <= 1'b0;
            end
            // A fire is held back until the next one, or the end of the scan, shows
            // whether it is the final one of the tick.
            if (fire) begin
                r_pend_valid <= 1'b1;
                r_out_valid  <= r_pend_valid;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= r_pend_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now  <= i_now_ms;
            r_tick <= i_tick_count;
        end
        if (i_cmd.pr_load) begin
            r_phase <= pr_rdata[TW-1:0];
        end
        if (fire) begin
            r_pend_src  <= i_cmd.pr_check ? pots_pkg::SRC_PERIODIC : pots_pkg::SRC_ONESHOT;
            r_pend_slot <= i_cmd.idx;
        end
        if (fire || i_cmd.flush) begin
            r_out_src  <= r_pend_src;
            r_out_slot <= r_pend_slot;
            r_out_tick <= r_tick;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_strobe    = r_out_valid;
    assign o_source    = r_out_src;
    assign o_fire_slot = r_out_slot;
    assign o_fire_tick = r_out_tick;
    assign o_last      = r_out_valid && r_out_last;

endmodule

// ===== hdl/pots_ctrl.sv =====
// Controller of the tick scheduler: accepts items and sequences the slot scan.
// Depends on pots_pkg.
module pots_ctrl #(
    parameter int ONESHOT_SLOTS  = pots_pkg::ONESHOT_SLOTS_DEF,
    parameter int PERIODIC_SLOTS = pots_pkg::PERIODIC_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pots_pkg::KIND_W-1:0] i_kind,
    input  pots_pkg::t_stat             i_stat,
    output pots_pkg::t_cmd              o_cmd,
    output logic                        o_busy
);

    localparam int SW = pots_pkg::SLOT_W;
    localparam logic [SW-1:0] OS_LAST = SW'(ONESHOT_SLOTS - 1);
    localparam logic [SW-1:0] PR_LAST = SW'(PERIODIC_SLOTS - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_OS_RD  = 7'b0000010,
        S_OS_CHK = 7'b0000100,
        S_PR_RD  = 7'b0001000,
        S_PR_LD  = 7'b0010000,
        S_PR_DIV = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] n_idx;
    logic          pr_next;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        pr_next = 1'b0;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start && (i_kind == pots_pkg::KIND_TICK)) begin
                    n_state = S_OS_RD;
                    n_idx   = '0;
                end
            end
            S_OS_RD: begin
                n_state = S_OS_CHK;
            end
            S_OS_CHK: begin
                o_cmd.os_check = 1'b1;
                if (r_idx == OS_LAST) begin
                    n_idx   = '0;
                    n_state = S_PR_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_OS_RD;
                end
            end
            S_PR_RD: begin
                n_state = S_PR_LD;
            end
            S_PR_LD: begin
                o_cmd.pr_load = 1'b1;
                if (i_stat.pr_en) begin
                    n_state = S_PR_DIV;
                end else begin
                    pr_next = 1'b1;
                end
            end
            S_PR_DIV: begin
                if (i_stat.mod_done) begin
                    o_cmd.pr_check = 1'b1;
                    pr_next        = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (pr_next) begin
            if (r_idx == PR_LAST) begin
                n_state = S_FLUSH;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_PR_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
